### rtl/core/ogrm_pkg.sv
// Shared types and constants of the occupancy grid ray marker.
package ogrm_pkg;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_RAY    = 2'd1,
    FN_PERSON = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CS_UNKNOWN  = 2'd0,
    CS_FREE     = 2'd1,
    CS_OCCUPIED = 2'd2,
    CS_PERSON   = 2'd3
  } cell_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_RD_ADR,
    S_RD_MEM,
    S_RD_CAP,
    S_RAY_SQ,
    S_RAY_RT,
    S_RAY_RTW,
    S_RAY_DX,
    S_RAY_DXW,
    S_RAY_DY,
    S_RAY_DYW,
    S_SMP,
    S_MUL,
    S_ADR,
    S_PER_CELL,
    S_DONE
  } state_t;

  localparam int STEP_MM = 100;

endpackage

### rtl/core/ogrm_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module ogrm_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] rem;
  logic [31:0] rt;
  logic [31:0] bitv;
  logic        run;
  logic [31:0] trial;

  assign trial = rt + bitv;
  assign root  = rt[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        rt   <= '0;
        bitv <= 32'h4000_0000;
        run  <= 1'b1;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          rt  <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 32'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/ogrm_div.sv
// Restoring divider, one quotient bit per cycle.
module ogrm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [21:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [21:0] quo,
  output logic [15:0] rem
);

  logic [16:0] prem;
  logic [4:0]  cnt;
  logic        run;
  logic [16:0] sh;

  assign sh  = {prem[15:0], quo[21]};
  assign rem = prem[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prem <= '0;
        quo  <= dividend;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (sh >= {1'b0, divisor}) begin
          prem <= sh - {1'b0, divisor};
          quo  <= {quo[20:0], 1'b1};
        end else begin
          prem <= sh;
          quo  <= {quo[20:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd21) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/ogrm_map_mem.sv
// Cell map memory: one write port and one registered read port.
module ogrm_map_mem #(
  parameter int DEPTH = 10000,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/occupancy_grid_ray_marker_core.sv
// Top level of the occupancy grid ray marker: sequencer, ray stepper and map.
//
// Channel   Signals                                   Handshake
// command   func x_mm y_mm cell_col cell_row          start high, busy low
// result    cell_state off_map                        done, one cycle
//
// Every item gives one result, marked by done, the cycle after its work ends.
// Work per item: clear passes over every cell, read looks up one cell, person
// marks the cell and its neighbours (none when off the map), and a lidar ray
// takes d/100 + 1 samples, one sample for a zero-length ray.
// After reset the same clearing pass runs with busy high and no result. The
// receiver cannot stall; busy holds off start.
module occupancy_grid_ray_marker_core #(
  parameter int GRID_CELLS = 100,
  parameter int CELL_MM    = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [15:0] x_mm,
  input  logic signed [15:0] y_mm,
  input  logic [7:0]         cell_col,
  input  logic [7:0]         cell_row,
  output logic               done,
  output logic [1:0]         cell_state,
  output logic               off_map
);

  localparam int SPAN  = GRID_CELLS * CELL_MM;
  localparam int DIVC  = 2 * CELL_MM;
  localparam int NW    = 19;
  localparam int LW    = $clog2(DIVC);
  localparam int K     = NW + LW;
  localparam int MW    = NW + 1;
  localparam int PW    = NW + MW;
  localparam int QW    = PW - K;
  localparam longint unsigned MREC = ((64'd1 << K) + DIVC - 1) / DIVC;
  localparam int DEPTH = GRID_CELLS * GRID_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_CELLS);

  ogrm_pkg::state_t state, state_next;

  logic [1:0]         fn_r;
  logic signed [15:0] x_r, y_r;
  logic [7:0]         rc_r, rr_r;
  logic               clr_item;
  logic [AW-1:0]      clr_cnt;

  logic               wr_en;
  logic [AW-1:0]      waddr;
  logic [1:0]         wdata;
  logic [AW-1:0]      raddr;
  logic [1:0]         rdata;
  logic               rd_off;

  logic [31:0] xsq, ysq;
  logic        sq_start, sq_done;
  logic [15:0] sq_root;
  logic        dv_start, dv_done;
  logic [21:0] dv_dividend, dv_quo;
  logic [15:0] dv_rem;

  logic [15:0] ray_len;
  logic [7:0]  qax, qay;
  logic [15:0] rax, ray;
  logic [16:0] qx, qy;
  logic [15:0] rx, ry;
  logic [16:0] acc;
  logic [16:0] ax, ay;

  logic signed [17:0] sx_c, sy_c;
  logic signed [20:0] nc_c, nr_c;
  logic [NW-1:0] nc_u, nr_u;
  logic          cneg, rneg, smp_neg;
  logic [PW-1:0] prod_c, prod_r;
  logic [QW-1:0] cq, rq;
  logic          cell_ok;
  logic [AW-1:0] cell_addr;
  logic          smp_occ;

  logic [IW-1:0]   pcol, prow;
  logic [1:0]      di, dj;
  logic [IW+1:0]   pc_e, pr_e;
  logic            pcell_ok;

  logic [16:0] rx_s, ry_s;
  logic [16:0] qx_n, qy_n;

  logic res_off;
  logic [1:0] res_state;

  ogrm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (xsq + ysq),
    .done     (sq_done),
    .root     (sq_root)
  );

  ogrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (ray_len),
    .done     (dv_done),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  ogrm_map_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ax = x_r[15] ? 17'(-$signed({x_r[15], x_r})) : 17'({1'b0, x_r});
  assign ay = y_r[15] ? 17'(-$signed({y_r[15], y_r})) : 17'({1'b0, y_r});
  assign sq_start = (state == ogrm_pkg::S_RAY_RT);
  assign dv_start = (state == ogrm_pkg::S_RAY_DX) || (state == ogrm_pkg::S_RAY_DY);
  assign dv_dividend = (state == ogrm_pkg::S_RAY_DX) ? 22'(ax) * 22'(ogrm_pkg::STEP_MM)
                                                     : 22'(ay) * 22'(ogrm_pkg::STEP_MM);

  always_comb begin
    if (fn_r == ogrm_pkg::FN_PERSON) begin
      sx_c = 18'(x_r);
      sy_c = 18'(y_r);
    end else begin
      sx_c = x_r[15] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      sy_c = y_r[15] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    nc_c = 21'(SPAN) + {{2{sx_c[17]}}, sx_c, 1'b0};
    nr_c = 21'(SPAN) - {{2{sy_c[17]}}, sy_c, 1'b0};
  end

  assign prod_c = PW'(nc_u) * PW'(MREC);
  assign prod_r = PW'(nr_u) * PW'(MREC);

  assign cell_ok = !smp_neg && (int'(cq) < GRID_CELLS) && (int'(rq) < GRID_CELLS);
  assign cell_addr = AW'(cq[IW-1:0]) * AW'(GRID_CELLS) + AW'(rq[IW-1:0]);
  assign smp_occ = (acc + 17'(ogrm_pkg::STEP_MM)) >= {1'b0, ray_len};

  assign pc_e = (IW+2)'(pcol) + (IW+2)'(di) - (IW+2)'(1);
  assign pr_e = (IW+2)'(prow) + (IW+2)'(dj) - (IW+2)'(1);
  assign pcell_ok = !pc_e[IW+1] && !pr_e[IW+1] &&
                    (int'(pc_e) < GRID_CELLS) && (int'(pr_e) < GRID_CELLS);

  assign rx_s = 17'(rx) + 17'(rax);
  assign ry_s = 17'(ry) + 17'(ray);
  assign qx_n = qx + 17'(qax) + 17'(rx_s >= {1'b0, ray_len});
  assign qy_n = qy + 17'(qay) + 17'(ry_s >= {1'b0, ray_len});

  always_comb begin
    state_next = state;
    unique case (state)
      ogrm_pkg::S_CLR: begin
        if (int'(clr_cnt) == DEPTH - 1) begin
          state_next = clr_item ? ogrm_pkg::S_DONE : ogrm_pkg::S_IDLE;
        end
      end
      ogrm_pkg::S_IDLE: begin
        if (start) begin
          unique case (ogrm_pkg::func_t'(func))
            ogrm_pkg::FN_CLEAR:  state_next = ogrm_pkg::S_CLR;
            ogrm_pkg::FN_RAY:    state_next = ogrm_pkg::S_RAY_SQ;
            ogrm_pkg::FN_PERSON: state_next = ogrm_pkg::S_SMP;
            ogrm_pkg::FN_READ:   state_next = ogrm_pkg::S_RD_ADR;
            default:             state_next = ogrm_pkg::S_IDLE;
          endcase
        end
      end
      ogrm_pkg::S_RD_ADR:  state_next = ogrm_pkg::S_RD_MEM;
      ogrm_pkg::S_RD_MEM:  state_next = ogrm_pkg::S_RD_CAP;
      ogrm_pkg::S_RD_CAP:  state_next = ogrm_pkg::S_DONE;
      ogrm_pkg::S_RAY_SQ:  state_next = ogrm_pkg::S_RAY_RT;
      ogrm_pkg::S_RAY_RT:  state_next = ogrm_pkg::S_RAY_RTW;
      ogrm_pkg::S_RAY_RTW: begin
        if (sq_done) begin
          state_next = (sq_root == 16'd0) ? ogrm_pkg::S_SMP : ogrm_pkg::S_RAY_DX;
        end
      end
      ogrm_pkg::S_RAY_DX:  state_next = ogrm_pkg::S_RAY_DXW;
      ogrm_pkg::S_RAY_DXW: if (dv_done) state_next = ogrm_pkg::S_RAY_DY;
      ogrm_pkg::S_RAY_DY:  state_next = ogrm_pkg::S_RAY_DYW;
      ogrm_pkg::S_RAY_DYW: if (dv_done) state_next = ogrm_pkg::S_SMP;
      ogrm_pkg::S_SMP: begin
        if (fn_r == ogrm_pkg::FN_RAY && acc > {1'b0, ray_len}) begin
          state_next = ogrm_pkg::S_DONE;
        end else begin
          state_next = ogrm_pkg::S_MUL;
        end
      end
      ogrm_pkg::S_MUL: state_next = ogrm_pkg::S_ADR;
      ogrm_pkg::S_ADR: begin
        if (fn_r == ogrm_pkg::FN_PERSON) begin
          state_next = cell_ok ? ogrm_pkg::S_PER_CELL : ogrm_pkg::S_DONE;
        end else begin
          state_next = ogrm_pkg::S_SMP;
        end
      end
      ogrm_pkg::S_PER_CELL: begin
        if (di == 2'd2 && dj == 2'd2) begin
          state_next = ogrm_pkg::S_DONE;
        end
      end
      ogrm_pkg::S_DONE: state_next = ogrm_pkg::S_IDLE;
      default:          state_next = ogrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ogrm_pkg::S_IDLE);
    done       = (state == ogrm_pkg::S_DONE);
    cell_state = res_state;
    off_map    = res_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ogrm_pkg::S_CLR;
      clr_item <= 1'b0;
      clr_cnt  <= '0;
      wr_en    <= 1'b0;
    end else begin
      state <= state_next;
      wr_en <= 1'b0;
      unique case (state)
        ogrm_pkg::S_CLR: begin
          wr_en   <= 1'b1;
          waddr   <= clr_cnt;
          wdata   <= ogrm_pkg::CS_UNKNOWN;
          clr_cnt <= clr_cnt + AW'(1);
        end
        ogrm_pkg::S_IDLE: begin
          if (start) begin
            fn_r      <= func;
            x_r       <= x_mm;
            y_r       <= y_mm;
            rc_r      <= cell_col;
            rr_r      <= cell_row;
            res_state <= ogrm_pkg::CS_UNKNOWN;
            res_off   <= 1'b0;
            clr_item  <= 1'b1;
            clr_cnt   <= '0;
            qx        <= '0;
            qy        <= '0;
            rx        <= '0;
            ry        <= '0;
            acc       <= '0;
            di        <= '0;
            dj        <= '0;
          end
        end
        ogrm_pkg::S_RD_ADR: begin
          rd_off <= (int'(rc_r) >= GRID_CELLS) || (int'(rr_r) >= GRID_CELLS);
          raddr  <= AW'(rc_r[IW-1:0]) * AW'(GRID_CELLS) + AW'(rr_r[IW-1:0]);
        end
        ogrm_pkg::S_RD_CAP: begin
          res_state <= rd_off ? ogrm_pkg::CS_UNKNOWN : rdata;
          res_off   <= rd_off;
        end
        ogrm_pkg::S_RAY_SQ: begin
          xsq <= 32'(x_r * x_r);
          ysq <= 32'(y_r * y_r);
        end
        ogrm_pkg::S_RAY_RTW: begin
          if (sq_done) begin
            ray_len <= sq_root;
            qax     <= '0;
            qay     <= '0;
            rax     <= '0;
            ray     <= '0;
          end
        end
        ogrm_pkg::S_RAY_DXW: begin
          if (dv_done) begin
            qax <= dv_quo[7:0];
            rax <= dv_rem;
          end
        end
        ogrm_pkg::S_RAY_DYW: begin
          if (dv_done) begin
            qay <= dv_quo[7:0];
            ray <= dv_rem;
          end
        end
        ogrm_pkg::S_SMP: begin
          nc_u    <= nc_c[NW-1:0];
          nr_u    <= nr_c[NW-1:0];
          cneg    <= nc_c[20];
          rneg    <= nr_c[20];
        end
        ogrm_pkg::S_MUL: begin
          cq      <= prod_c[PW-1:K];
          rq      <= prod_r[PW-1:K];
          smp_neg <= cneg || rneg;
        end
        ogrm_pkg::S_ADR: begin
          if (fn_r == ogrm_pkg::FN_PERSON) begin
            pcol    <= cq[IW-1:0];
            prow    <= rq[IW-1:0];
            res_off <= !cell_ok;
          end else begin
            wr_en <= cell_ok;
            waddr <= cell_addr;
            wdata <= smp_occ ? ogrm_pkg::CS_OCCUPIED : ogrm_pkg::CS_FREE;
            qx    <= qx_n;
            qy    <= qy_n;
            rx    <= (rx_s >= {1'b0, ray_len}) ? 16'(rx_s - {1'b0, ray_len}) : rx_s[15:0];
            ry    <= (ry_s >= {1'b0, ray_len}) ? 16'(ry_s - {1'b0, ray_len}) : ry_s[15:0];
            acc   <= acc + 17'(ogrm_pkg::STEP_MM);
          end
        end
        ogrm_pkg::S_PER_CELL: begin
          wr_en <= pcell_ok;
          waddr <= AW'(pc_e[IW-1:0]) * AW'(GRID_CELLS) + AW'(pr_e[IW-1:0]);
          wdata <= ogrm_pkg::CS_PERSON;
          if (dj == 2'd2) begin
            dj <= '0;
            di <= di + 2'd1;
          end else begin
            dj <= dj + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### bench/tb.sv
// Self-checking testbench of the occupancy grid ray marker core.
`timescale 1ns / 1ps

module tb;

  localparam int GRID = 100;
  localparam int CELL = 100;

  typedef struct packed {
    ogrm_pkg::cell_t st;
    logic            off;
  } cell_reply_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic signed [15:0] x_mm;
  logic signed [15:0] y_mm;
  logic [7:0]         cell_col;
  logic [7:0]         cell_row;
  logic               done;
  logic [1:0]         cell_state;
  logic               off_map;

  ogrm_pkg::cell_t shadow_map [GRID * GRID];
  cell_reply_t     pending_replies [$];
  int              mismatches;
  int              idle_pct;
  int              items_sent;
  int              func_count [4];
  int              known_reads;
  int              off_replies;

  occupancy_grid_ray_marker_core #(
    .GRID_CELLS(GRID),
    .CELL_MM(CELL)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .x_mm(x_mm),
    .y_mm(y_mm),
    .cell_col(cell_col),
    .cell_row(cell_row),
    .done(done),
    .cell_state(cell_state),
    .off_map(off_map)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint int_root(longint n);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit point_to_cell(longint x, longint y, output longint col,
                                       output longint row);
    longint nc;
    longint nr;
    nc = GRID * CELL + 2 * x;
    nr = GRID * CELL - 2 * y;
    col = 0;
    row = 0;
    if (nc < 0 || nr < 0) return 1'b0;
    col = nc / (2 * CELL);
    row = nr / (2 * CELL);
    return col < GRID && row < GRID;
  endfunction

  function automatic void paint(longint col, longint row, ogrm_pkg::cell_t st);
    if (col >= 0 && row >= 0 && col < GRID && row < GRID) shadow_map[col * GRID + row] = st;
  endfunction

  function automatic cell_reply_t apply_item(ogrm_pkg::func_t f, longint x, longint y,
                                             int c, int r);
    cell_reply_t rep;
    longint ray_len;
    longint sx;
    longint sy;
    longint col;
    longint row;
    rep.st = ogrm_pkg::CS_UNKNOWN;
    rep.off = 1'b0;
    case (f)
      ogrm_pkg::FN_CLEAR: begin
        foreach (shadow_map[k]) shadow_map[k] = ogrm_pkg::CS_UNKNOWN;
      end
      ogrm_pkg::FN_RAY: begin
        ray_len = int_root(x * x + y * y);
        for (longint i = 0; i <= ray_len / ogrm_pkg::STEP_MM; i++) begin
          sx = (ray_len != 0) ? (x * i * ogrm_pkg::STEP_MM) / ray_len : 0;
          sy = (ray_len != 0) ? (y * i * ogrm_pkg::STEP_MM) / ray_len : 0;
          if (point_to_cell(sx, sy, col, row))
            paint(col, row, (i * ogrm_pkg::STEP_MM >= ray_len - ogrm_pkg::STEP_MM) ?
                            ogrm_pkg::CS_OCCUPIED : ogrm_pkg::CS_FREE);
        end
      end
      ogrm_pkg::FN_PERSON: begin
        if (!point_to_cell(x, y, col, row)) rep.off = 1'b1;
        else
          for (int i = -1; i <= 1; i++)
            for (int j = -1; j <= 1; j++) paint(col + i, row + j, ogrm_pkg::CS_PERSON);
      end
      default: begin
        if (c >= GRID || r >= GRID) rep.off = 1'b1;
        else rep.st = shadow_map[c * GRID + r];
      end
    endcase
    return rep;
  endfunction

  task automatic send_item(ogrm_pkg::func_t f, logic signed [15:0] x,
                           logic signed [15:0] y, logic [7:0] c, logic [7:0] r);
    @(negedge clk);
    func <= f;
    x_mm <= x;
    y_mm <= y;
    cell_col <= c;
    cell_row <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies = {pending_replies, apply_item(f, x, y, c, r)};
    items_sent++;
    func_count[f]++;
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic wait_all_replies();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_replies.size() == 0);
  endtask

  always @(posedge clk) begin
    cell_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (cell_state !== want.st) begin
          $error("cell_state expected %0d got %0d", want.st, cell_state);
          mismatches++;
        end
        if (off_map !== want.off) begin
          $error("off_map expected %0d got %0d", want.off, off_map);
          mismatches++;
        end
        if (want.st != ogrm_pkg::CS_UNKNOWN) known_reads++;
        if (want.off) off_replies++;
      end
    end
  end

  task automatic test_reads_after_reset();
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd99, 8'd99);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd100, 8'd0);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd0, 8'd100);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd255, 8'd255);
  endtask

  task automatic test_ray_cases();
    send_item(ogrm_pkg::FN_RAY, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_RAY, 16'sd300, 16'sd400, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_RAY, 16'sd5000, 16'sd0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_RAY, 16'sd32767, -16'sd32768, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_RAY, -16'sd32768, 16'sd32767, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_RAY, -16'sd4999, -16'sd4999, 8'd0, 8'd0);
  endtask

  task automatic test_person_cases();
    send_item(ogrm_pkg::FN_PERSON, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_PERSON, 16'sd4999, -16'sd4999, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_PERSON, -16'sd5000, 16'sd5000, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_PERSON, 16'sd5000, 16'sd0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_PERSON, 16'sd0, -16'sd5000, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_PERSON, -16'sd5001, 16'sd0, 8'd0, 8'd0);
  endtask

  task automatic test_clear_map();
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd50, 8'd50);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd99, 8'd99);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_CLEAR, 0, 0, 8'd0, 8'd0);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd50, 8'd50);
    send_item(ogrm_pkg::FN_READ, 0, 0, 8'd99, 8'd99);
    wait_all_replies();
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0] c;
    logic [7:0] r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 199);
      if ($urandom_range(0, 4) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($signed($urandom_range(0, 10400)) - 16'sd5200);
        y = 16'($signed($urandom_range(0, 10400)) - 16'sd5200);
      end
      if ($urandom_range(0, 6) == 0) begin
        c = 8'($urandom);
        r = 8'($urandom);
      end else begin
        c = 8'($urandom_range(0, GRID - 1));
        r = 8'($urandom_range(0, GRID - 1));
      end
      if (pick == 0) send_item(ogrm_pkg::FN_CLEAR, x, y, c, r);
      else if (pick < 90) send_item(ogrm_pkg::FN_RAY, x, y, c, r);
      else if (pick < 120) send_item(ogrm_pkg::FN_PERSON, x, y, c, r);
      else send_item(ogrm_pkg::FN_READ, x, y, c, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = ogrm_pkg::FN_CLEAR;
    x_mm = '0;
    y_mm = '0;
    cell_col = '0;
    cell_row = '0;
    mismatches = 0;
    idle_pct = 0;
    items_sent = 0;
    known_reads = 0;
    off_replies = 0;
    foreach (func_count[k]) func_count[k] = 0;
    foreach (shadow_map[k]) shadow_map[k] = ogrm_pkg::CS_UNKNOWN;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reads_after_reset();
    test_ray_cases();
    test_person_cases();
    test_clear_map();

    idle_pct = 32;
    test_random_traffic(200);
    wait_all_replies();
    idle_pct = 73;
    test_random_traffic(200);
    wait_all_replies();
    idle_pct = 0;
    test_random_traffic(200);
    wait_all_replies();
    repeat (20) @(posedge clk);

    $display("Sent %0d items: %0d clears, %0d rays, %0d persons, %0d reads.",
             items_sent, func_count[ogrm_pkg::FN_CLEAR], func_count[ogrm_pkg::FN_RAY],
             func_count[ogrm_pkg::FN_PERSON], func_count[ogrm_pkg::FN_READ]);
    $display("Reads of marked cells: %0d, off-map replies: %0d.", known_reads, off_replies);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results outstanding.", pending_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
